[design/assert_macros.svh]
// assertion macros used by the token assembler's result register (mta_emit)
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed");

// next-cycle implication, quiet during reset
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("assertion failed");

`endif

[design/mta_pkg.sv]
// shared types, codes and opcode lookup for the token assembler
// no dependencies
`timescale 1ns / 1ps

package mta_pkg;

	// token kinds
	localparam logic [3:0] K_NEWLINE = 4'd0;
	localparam logic [3:0] K_MNEMONIC = 4'd1;
	localparam logic [3:0] K_HASH = 4'd2;
	localparam logic [3:0] K_OPEN = 4'd3;
	localparam logic [3:0] K_CLOSE = 4'd4;
	localparam logic [3:0] K_COMMA_X = 4'd5;
	localparam logic [3:0] K_COMMA_Y = 4'd6;
	localparam logic [3:0] K_NUM8 = 4'd7;
	localparam logic [3:0] K_NUM16 = 4'd8;
	localparam logic [3:0] K_END = 4'd9;

	// result status codes
	localparam logic [3:0] S_BYTE = 4'd0;
	localparam logic [3:0] S_DONE = 4'd1;
	localparam logic [3:0] S_EXP_INSTR = 4'd2;
	localparam logic [3:0] S_BAD_OPERAND = 4'd3;
	localparam logic [3:0] S_NO_OPCODE = 4'd4;
	localparam logic [3:0] S_EXP_NEWLINE = 4'd5;
	localparam logic [3:0] S_INDEX_BRANCH = 4'd6;
	localparam logic [3:0] S_EXP_CLOSE = 4'd7;
	localparam logic [3:0] S_EXP_NUMBER = 4'd8;
	localparam logic [3:0] S_BAD_INDIRECT = 4'd9;

	// addressing modes
	localparam logic [3:0] M_NONE = 4'd0;
	localparam logic [3:0] M_IMP = 4'd1;
	localparam logic [3:0] M_IMM = 4'd2;
	localparam logic [3:0] M_ZP0 = 4'd3;
	localparam logic [3:0] M_ZPX = 4'd4;
	localparam logic [3:0] M_ZPY = 4'd5;
	localparam logic [3:0] M_REL = 4'd6;
	localparam logic [3:0] M_ABS = 4'd7;
	localparam logic [3:0] M_ABX = 4'd8;
	localparam logic [3:0] M_ABY = 4'd9;
	localparam logic [3:0] M_IZX = 4'd10;
	localparam logic [3:0] M_IZY = 4'd11;
	localparam logic [3:0] M_IND = 4'd12;

	localparam logic [23:0] MN_JMP = "JMP";
	localparam logic [7:0] JMP_IND_OPCODE = 8'h6C;

	typedef struct packed {
		logic [7:0] data;
		logic [3:0] status;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t [2:0] res;
	} batch_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] op;
	} lookup_t;

	typedef enum logic [3:0] {
		G_NONE, G_ALU, G_SHF, G_INC, G_STX, G_LDX, G_STY, G_LDY, G_CP, G_BIT,
		G_BR, G_IMP, G_JMP, G_JSR, G_BRK
	} grp_t;

	function automatic logic is_branch(logic [23:0] mn);
		return mn == "BPL" || mn == "BMI" || mn == "BVC" || mn == "BVS" ||
			mn == "BCC" || mn == "BCS" || mn == "BNE" || mn == "BEQ";
	endfunction

	// opcode = group base + mode offset
	function automatic lookup_t find_op(logic [23:0] mn, logic [3:0] mode);
		grp_t       grp;
		logic [7:0] base;
		logic [7:0] off;
		logic       ok;
		lookup_t    r;
		grp = G_NONE;
		base = 8'h00;
		off = 8'h00;
		ok = 1'b0;
		case (mn)
			"ORA": begin grp = G_ALU; base = 8'h01; end
			"AND": begin grp = G_ALU; base = 8'h21; end
			"EOR": begin grp = G_ALU; base = 8'h41; end
			"ADC": begin grp = G_ALU; base = 8'h61; end
			"STA": begin grp = G_ALU; base = 8'h81; end
			"LDA": begin grp = G_ALU; base = 8'hA1; end
			"CMP": begin grp = G_ALU; base = 8'hC1; end
			"SBC": begin grp = G_ALU; base = 8'hE1; end
			"ASL": begin grp = G_SHF; base = 8'h02; end
			"ROL": begin grp = G_SHF; base = 8'h22; end
			"LSR": begin grp = G_SHF; base = 8'h42; end
			"ROR": begin grp = G_SHF; base = 8'h62; end
			"DEC": begin grp = G_INC; base = 8'hC2; end
			"INC": begin grp = G_INC; base = 8'hE2; end
			"STX": begin grp = G_STX; base = 8'h82; end
			"LDX": begin grp = G_LDX; base = 8'hA2; end
			"STY": begin grp = G_STY; base = 8'h80; end
			"LDY": begin grp = G_LDY; base = 8'hA0; end
			"CPY": begin grp = G_CP; base = 8'hC0; end
			"CPX": begin grp = G_CP; base = 8'hE0; end
			"BIT": begin grp = G_BIT; base = 8'h20; end
			"BPL": begin grp = G_BR; base = 8'h10; end
			"BMI": begin grp = G_BR; base = 8'h30; end
			"BVC": begin grp = G_BR; base = 8'h50; end
			"BVS": begin grp = G_BR; base = 8'h70; end
			"BCC": begin grp = G_BR; base = 8'h90; end
			"BCS": begin grp = G_BR; base = 8'hB0; end
			"BNE": begin grp = G_BR; base = 8'hD0; end
			"BEQ": begin grp = G_BR; base = 8'hF0; end
			"PHP": begin grp = G_IMP; base = 8'h08; end
			"CLC": begin grp = G_IMP; base = 8'h18; end
			"PLP": begin grp = G_IMP; base = 8'h28; end
			"SEC": begin grp = G_IMP; base = 8'h38; end
			"RTI": begin grp = G_IMP; base = 8'h40; end
			"PHA": begin grp = G_IMP; base = 8'h48; end
			"CLI": begin grp = G_IMP; base = 8'h58; end
			"RTS": begin grp = G_IMP; base = 8'h60; end
			"PLA": begin grp = G_IMP; base = 8'h68; end
			"SEI": begin grp = G_IMP; base = 8'h78; end
			"DEY": begin grp = G_IMP; base = 8'h88; end
			"TXA": begin grp = G_IMP; base = 8'h8A; end
			"TYA": begin grp = G_IMP; base = 8'h98; end
			"TXS": begin grp = G_IMP; base = 8'h9A; end
			"TAY": begin grp = G_IMP; base = 8'hA8; end
			"TAX": begin grp = G_IMP; base = 8'hAA; end
			"CLV": begin grp = G_IMP; base = 8'hB8; end
			"TSX": begin grp = G_IMP; base = 8'hBA; end
			"INY": begin grp = G_IMP; base = 8'hC8; end
			"DEX": begin grp = G_IMP; base = 8'hCA; end
			"CLD": begin grp = G_IMP; base = 8'hD8; end
			"INX": begin grp = G_IMP; base = 8'hE8; end
			"NOP": begin grp = G_IMP; base = 8'hEA; end
			"SED": begin grp = G_IMP; base = 8'hF8; end
			"JMP": begin grp = G_JMP; base = 8'h4C; end
			"JSR": begin grp = G_JSR; base = 8'h20; end
			"BRK": begin grp = G_BRK; base = 8'h00; end
			default: begin grp = G_NONE; base = 8'h00; end
		endcase
		case (grp)
			G_ALU: begin
				case (mode)
					M_IZX: begin ok = 1'b1; off = 8'h00; end
					M_ZP0: begin ok = 1'b1; off = 8'h04; end
					M_IMM: begin ok = (base != 8'h81); off = 8'h08; end
					M_ABS: begin ok = 1'b1; off = 8'h0C; end
					M_IZY: begin ok = 1'b1; off = 8'h10; end
					M_ZPX: begin ok = 1'b1; off = 8'h14; end
					M_ABY: begin ok = 1'b1; off = 8'h18; end
					M_ABX: begin ok = 1'b1; off = 8'h1C; end
					default: ok = 1'b0;
				endcase
			end
			G_SHF: begin
				case (mode)
					M_ZP0: begin ok = 1'b1; off = 8'h04; end
					M_IMP: begin ok = 1'b1; off = 8'h08; end
					M_ABS: begin ok = 1'b1; off = 8'h0C; end
					M_ZPX: begin ok = 1'b1; off = 8'h14; end
					M_ABX: begin ok = 1'b1; off = 8'h1C; end
					default: ok = 1'b0;
				endcase
			end
			G_INC: begin
				case (mode)
					M_ZP0: begin ok = 1'b1; off = 8'h04; end
					M_ABS: begin ok = 1'b1; off = 8'h0C; end
					M_ZPX: begin ok = 1'b1; off = 8'h14; end
					M_ABX: begin ok = 1'b1; off = 8'h1C; end
					default: ok = 1'b0;
				endcase
			end
			G_STX: begin
				case (mode)
					M_ZP0: begin ok = 1'b1; off = 8'h04; end
					M_ABS: begin ok = 1'b1; off = 8'h0C; end
					M_ZPY: begin ok = 1'b1; off = 8'h14; end
					default: ok = 1'b0;
				endcase
			end
			G_LDX: begin
				case (mode)
					M_IMM: begin ok = 1'b1; off = 8'h00; end
					M_ZP0: begin ok = 1'b1; off = 8'h04; end
					M_ABS: begin ok = 1'b1; off = 8'h0C; end
					M_ZPY: begin ok = 1'b1; off = 8'h14; end
					M_ABY: begin ok = 1'b1; off = 8'h1C; end
					default: ok = 1'b0;
				endcase
			end
			G_STY: begin
				case (mode)
					M_ZP0: begin ok = 1'b1; off = 8'h04; end
					M_ABS: begin ok = 1'b1; off = 8'h0C; end
					M_ZPX: begin ok = 1'b1; off = 8'h14; end
					default: ok = 1'b0;
				endcase
			end
			G_LDY: begin
				case (mode)
					M_IMM: begin ok = 1'b1; off = 8'h00; end
					M_ZP0: begin ok = 1'b1; off = 8'h04; end
					M_ABS: begin ok = 1'b1; off = 8'h0C; end
					M_ZPX: begin ok = 1'b1; off = 8'h14; end
					M_ABX: begin ok = 1'b1; off = 8'h1C; end
					default: ok = 1'b0;
				endcase
			end
			G_CP: begin
				case (mode)
					M_IMM: begin ok = 1'b1; off = 8'h00; end
					M_ZP0: begin ok = 1'b1; off = 8'h04; end
					M_ABS: begin ok = 1'b1; off = 8'h0C; end
					default: ok = 1'b0;
				endcase
			end
			G_BIT: begin
				case (mode)
					M_ZP0: begin ok = 1'b1; off = 8'h04; end
					M_ABS: begin ok = 1'b1; off = 8'h0C; end
					default: ok = 1'b0;
				endcase
			end
			G_BR: ok = (mode == M_REL);
			G_IMP: ok = (mode == M_IMP);
			G_JMP: begin
				case (mode)
					M_ABS: begin ok = 1'b1; off = 8'h00; end
					M_IND: begin ok = 1'b1; off = 8'h20; end
					default: ok = 1'b0;
				endcase
			end
			G_JSR: ok = (mode == M_ABS);
			G_BRK: ok = (mode == M_IMM);
			default: ok = 1'b0;
		endcase
		r.ok = ok;
		r.op = base + off;
		return r;
	endfunction

	// opcode followed by its operand bytes
	function automatic batch_t instr_batch(logic [7:0] op, logic [3:0] mode, logic [15:0] val);
		batch_t b;
		b = '0;
		b.res[0].data = op;
		if (mode == M_IMP) begin
			b.cnt = 2'd1;
		end else begin
			b.res[1].data = val[7:0];
			if (mode == M_ABS || mode == M_ABX || mode == M_ABY || mode == M_IND) begin
				b.res[2].data = val[15:8];
				b.cnt = 2'd3;
			end else begin
				b.cnt = 2'd2;
			end
		end
		return b;
	endfunction

	function automatic batch_t status_batch(logic [3:0] code);
		batch_t b;
		b = '0;
		b.cnt = 2'd1;
		b.res[0].status = code;
		return b;
	endfunction

endpackage

[design/mos6502_token_assembler.sv]
// top level of the streaming 6502 token assembler
// depends on mta_pkg, mta_parse and mta_emit
`timescale 1ns / 1ps

// usage:
// input channel takes one lexed token word (kind, mnemonic, value) per
// accepted handshake; output channel gives one result word (out_byte,
// is_last, status) per handshake. a token yields zero to three words and
// is_last marks the final word of each token.
// a token is registered in the input register on acceptance, decoded
// combinationally and loaded as a batch into the result register.
// the single result register sends one word per cycle while out_stall is
// low; a token is taken when that register is empty or its last word
// leaves, so an instruction with a 16-bit operand holds the input until
// its three words are sent.
// while the receiver stalls, the current word holds and the next token
// waits in the input register; in_stall rises once that register is full.
// reset clears the parse state, the held mnemonic and operand, and the
// error latch; after an error every token is consumed with no words
// until the next reset.

module mos6502_token_assembler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  kind,
	input  logic [23:0] mnemonic,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        is_last,
	output logic [3:0]  status
);

	logic            vld_s1;
	logic [3:0]      kind_s1;
	logic [23:0]     mnemonic_s1;
	logic [15:0]     value_s1;
	logic            free;
	logic            take;
	mta_pkg::batch_t batch;

	assign take = vld_s1 && free;
	assign in_stall = vld_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			mnemonic_s1 <= mnemonic;
			value_s1 <= value;
		end
	end

	mta_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.kind     (kind_s1),
		.mnemonic (mnemonic_s1),
		.value    (value_s1),
		.batch    (batch)
	);

	mta_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.batch     (batch),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.is_last   (is_last),
		.status    (status)
	);

endmodule

[design/mta_parse.sv]
// parse state machine: turns one token into a batch of up to three results
// depends on mta_pkg
`timescale 1ns / 1ps

module mta_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [3:0]          kind,
	input  logic [23:0]         mnemonic,
	input  logic [15:0]         value,
	output mta_pkg::batch_t     batch
);

	typedef enum logic [3:0] {
		ST_INSTR, ST_OPER, ST_IMM, ST_ZP, ST_ABS, ST_EOL, ST_PAREN, ST_IND16,
		ST_IND8, ST_IZX_CLOSE, ST_IZY_Y, ST_FINISHED
	} pstate_t;

	pstate_t          state_q, state_d;
	logic [23:0]      mn_q, mn_d;
	logic [15:0]      val_q, val_d;
	logic             err_q, err_d;
	logic [3:0]       mode;
	logic             zp;
	mta_pkg::lookup_t lk;
	mta_pkg::batch_t  b;

	always_comb begin
		state_d = state_q;
		mn_d = mn_q;
		val_d = val_q;
		err_d = err_q;
		b = '0;
		mode = mta_pkg::M_NONE;
		zp = (state_q == ST_ZP);
		lk = '0;
		if (!err_q) begin
			case (state_q)
				ST_OPER: begin
					if (kind == mta_pkg::K_NEWLINE) begin
						lk = mta_pkg::find_op(mn_q, mta_pkg::M_IMP);
						if (!lk.ok) begin
							b = mta_pkg::status_batch(mta_pkg::S_NO_OPCODE);
							err_d = 1'b1;
						end else begin
							state_d = ST_INSTR;
							b = mta_pkg::instr_batch(lk.op, mta_pkg::M_IMP, val_q);
						end
					end else if (kind == mta_pkg::K_HASH) begin
						state_d = ST_IMM;
					end else if (kind == mta_pkg::K_OPEN) begin
						state_d = ST_PAREN;
					end else if (kind == mta_pkg::K_NUM16) begin
						val_d = value;
						state_d = ST_ABS;
					end else if (kind == mta_pkg::K_NUM8) begin
						val_d = value;
						state_d = ST_ZP;
					end else begin
						b = mta_pkg::status_batch(mta_pkg::S_BAD_OPERAND);
						err_d = 1'b1;
					end
				end
				ST_IMM: begin
					lk = mta_pkg::find_op(mn_q, mta_pkg::M_IMM);
					if (kind != mta_pkg::K_NUM8) begin
						b = mta_pkg::status_batch(mta_pkg::S_EXP_NUMBER);
						err_d = 1'b1;
					end else if (!lk.ok) begin
						b = mta_pkg::status_batch(mta_pkg::S_NO_OPCODE);
						err_d = 1'b1;
					end else begin
						val_d = value;
						state_d = ST_EOL;
						b = mta_pkg::instr_batch(lk.op, mta_pkg::M_IMM, value);
					end
				end
				ST_ZP, ST_ABS: begin
					mode = zp ? mta_pkg::M_ZP0 : mta_pkg::M_ABS;
					if (kind == mta_pkg::K_COMMA_X) begin
						mode = mode + 4'd1;
					end else if (kind == mta_pkg::K_COMMA_Y) begin
						mode = mode + 4'd2;
					end
					if (zp && mta_pkg::is_branch(mn_q) && mode == mta_pkg::M_ZP0) begin
						mode = mta_pkg::M_REL;
					end
					lk = mta_pkg::find_op(mn_q, mode);
					if (zp && mta_pkg::is_branch(mn_q) && mode != mta_pkg::M_REL) begin
						b = mta_pkg::status_batch(mta_pkg::S_INDEX_BRANCH);
						err_d = 1'b1;
					end else if (!lk.ok) begin
						b = mta_pkg::status_batch(mta_pkg::S_NO_OPCODE);
						err_d = 1'b1;
					end else if (kind == mta_pkg::K_COMMA_X || kind == mta_pkg::K_COMMA_Y) begin
						state_d = ST_EOL;
						b = mta_pkg::instr_batch(lk.op, mode, val_q);
					end else if (kind == mta_pkg::K_NEWLINE) begin
						state_d = ST_INSTR;
						b = mta_pkg::instr_batch(lk.op, mode, val_q);
					end else if (kind == mta_pkg::K_END) begin
						state_d = ST_FINISHED;
						b = mta_pkg::instr_batch(lk.op, mode, val_q);
						// room left in the batch: done rides along
						if (b.cnt == 2'd2) begin
							b.res[2].status = mta_pkg::S_DONE;
							b.cnt = 2'd3;
						end else if (b.cnt == 2'd1) begin
							b.res[1].status = mta_pkg::S_DONE;
							b.cnt = 2'd2;
						end
					end else begin
						b = mta_pkg::status_batch(mta_pkg::S_EXP_NEWLINE);
						err_d = 1'b1;
					end
				end
				ST_EOL: begin
					if (kind == mta_pkg::K_NEWLINE) begin
						state_d = ST_INSTR;
					end else if (kind == mta_pkg::K_END) begin
						state_d = ST_FINISHED;
						b = mta_pkg::status_batch(mta_pkg::S_DONE);
					end else begin
						b = mta_pkg::status_batch(mta_pkg::S_EXP_NEWLINE);
						err_d = 1'b1;
					end
				end
				ST_PAREN: begin
					if (kind == mta_pkg::K_NUM16) begin
						if (mn_q != mta_pkg::MN_JMP) begin
							b = mta_pkg::status_batch(mta_pkg::S_NO_OPCODE);
							err_d = 1'b1;
						end else begin
							val_d = value;
							state_d = ST_IND16;
						end
					end else if (kind == mta_pkg::K_NUM8) begin
						val_d = value;
						state_d = ST_IND8;
					end else begin
						b = mta_pkg::status_batch(mta_pkg::S_EXP_NUMBER);
						err_d = 1'b1;
					end
				end
				ST_IND16: begin
					if (kind != mta_pkg::K_CLOSE) begin
						b = mta_pkg::status_batch(mta_pkg::S_EXP_CLOSE);
						err_d = 1'b1;
					end else begin
						state_d = ST_EOL;
						b = mta_pkg::instr_batch(mta_pkg::JMP_IND_OPCODE, mta_pkg::M_IND, val_q);
					end
				end
				ST_IND8: begin
					lk = mta_pkg::find_op(mn_q, mta_pkg::M_IZX);
					if (kind == mta_pkg::K_COMMA_X) begin
						if (!lk.ok) begin
							b = mta_pkg::status_batch(mta_pkg::S_NO_OPCODE);
							err_d = 1'b1;
						end else begin
							state_d = ST_IZX_CLOSE;
							b = mta_pkg::instr_batch(lk.op, mta_pkg::M_IZX, val_q);
						end
					end else if (kind == mta_pkg::K_CLOSE) begin
						state_d = ST_IZY_Y;
					end else begin
						b = mta_pkg::status_batch(mta_pkg::S_BAD_INDIRECT);
						err_d = 1'b1;
					end
				end
				ST_IZX_CLOSE: begin
					if (kind != mta_pkg::K_CLOSE) begin
						b = mta_pkg::status_batch(mta_pkg::S_EXP_CLOSE);
						err_d = 1'b1;
					end else begin
						state_d = ST_INSTR;
					end
				end
				ST_IZY_Y: begin
					lk = mta_pkg::find_op(mn_q, mta_pkg::M_IZY);
					if (kind != mta_pkg::K_COMMA_Y) begin
						b = mta_pkg::status_batch(mta_pkg::S_BAD_INDIRECT);
						err_d = 1'b1;
					end else if (!lk.ok) begin
						b = mta_pkg::status_batch(mta_pkg::S_NO_OPCODE);
						err_d = 1'b1;
					end else begin
						state_d = ST_INSTR;
						b = mta_pkg::instr_batch(lk.op, mta_pkg::M_IZY, val_q);
					end
				end
				ST_FINISHED: begin
					b = mta_pkg::status_batch(mta_pkg::S_DONE);
				end
				default: begin
					// start of a line
					if (kind == mta_pkg::K_NEWLINE) begin
						state_d = ST_INSTR;
					end else if (kind == mta_pkg::K_MNEMONIC) begin
						mn_d = mnemonic;
						state_d = ST_OPER;
					end else if (kind == mta_pkg::K_END) begin
						state_d = ST_FINISHED;
						b = mta_pkg::status_batch(mta_pkg::S_DONE);
					end else begin
						b = mta_pkg::status_batch(mta_pkg::S_EXP_INSTR);
						err_d = 1'b1;
					end
				end
			endcase
		end
	end

	assign batch = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INSTR;
			mn_q <= '0;
			val_q <= '0;
			err_q <= 1'b0;
		end else if (take) begin
			state_q <= state_d;
			mn_q <= mn_d;
			val_q <= val_d;
			err_q <= err_d;
		end
	end

endmodule

[design/mta_emit.sv]
// result register: holds one batch and shifts it out one word per cycle while out_stall is low
// depends on mta_pkg and assert_macros.svh
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mta_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  mta_pkg::batch_t batch,
	output logic            free,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      out_byte,
	output logic            is_last,
	output logic [3:0]      status
);

	logic [1:0]            cnt_q;
	mta_pkg::res_t [2:0]   res_q;
	logic                  out_take;

	assign out_valid = (cnt_q != 2'd0);
	assign out_take = out_valid && !out_stall;
	// a new batch may land when this one is empty or its last word leaves now
	assign free = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !out_stall);
	assign out_byte = res_q[0].data;
	assign status = res_q[0].status;
	assign is_last = (cnt_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= batch.cnt;
		end else if (out_take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= batch.res;
		end else if (out_take) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	`ASSERT_IMPLY(a_load_when_free, clk, arst_n, load, (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_take))
	`ASSERT_IMPLY(a_status_is_last, clk, arst_n, out_valid && status != mta_pkg::S_BYTE, is_last)
	`ASSERT_NEXT(a_more_follow, clk, arst_n, out_take && !is_last, out_valid)

endmodule
